[rtl/cftx_pkg.sv]
// Package for the CAN transmit frame queue: transaction structs, frame record,
// command codes and the small helper used by the top level.
// No dependencies.
`default_nettype none

package cftx_pkg;

    // Default queue depth handed to the top-level parameter
    localparam int QUEUE_DEPTH_DEF = 16;

    // Width of the reported fill level
    localparam int QUEUED_W = 5;

    // Command codes
    localparam logic [1:0] CMD_PUSH_STD = 2'd0;
    localparam logic [1:0] CMD_PUSH_EXT = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    localparam logic [3:0]  MAX_LEN = 4'd8;
    localparam logic [28:0] STD_ID_MASK = 29'h000007FF;

    // Sender states
    typedef enum logic {
        SND_IDLE,
        SND_WAIT
    } sender_state_t;

    // Input transaction
    typedef struct packed {
        logic [1:0]  cmd;
        logic [28:0] frame_id;
        logic [3:0]  data_len;
        logic [63:0] payload;
        logic        tx_done;
        logic        bus_off;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic        accepted;
        logic        tx_start;
        logic [28:0] tx_id;
        logic        tx_extended;
        logic [3:0]  tx_len;
        logic [63:0] tx_payload;
        logic        clear_tx_request;
        logic        reinit_request;
        logic        waiting;
        logic [31:0] overflow_count;
        logic [QUEUED_W-1:0] queued;
    } out_item_t;

    // One stored frame
    typedef struct packed {
        logic        ext;
        logic [28:0] id;
        logic [3:0]  len;
        logic [63:0] payload;
    } frame_t;

    // Per-cycle commands to the cell row
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } chain_ctrl_t;

    // Status from the cell row
    typedef struct packed {
        logic head_valid;
        logic full;
    } chain_stat_t;

    // Build the stored frame from a push: saturate length, zero unused bytes
    function automatic frame_t make_frame(input in_item_t item);
        frame_t      f;
        logic [3:0]  len;
        logic [63:0] pay;
        len = (item.data_len > MAX_LEN) ? MAX_LEN : item.data_len;
        for (int b = 0; b < 8; b++) begin
            pay[b*8 +: 8] = (4'(b) < len) ? item.payload[b*8 +: 8] : 8'h00;
        end
        f.ext     = (item.cmd == CMD_PUSH_EXT);
        f.id      = f.ext ? item.frame_id : (item.frame_id & STD_ID_MASK);
        f.len     = len;
        f.payload = pay;
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/cftx_cell.sv]
// One storage cell of the frame queue row: a valid flag and one frame.
// Takes its right neighbor's contents on a pop. Depends on cftx_pkg.
`default_nettype none

module cftx_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  cftx_pkg::chain_ctrl_t ctrl,
    input  wire                  prev_valid,
    input  wire                  next_valid,
    input  cftx_pkg::frame_t     next_frame,
    input  cftx_pkg::frame_t     new_frame,
    output logic                 valid,
    output cftx_pkg::frame_t     frame
);

    logic             valid_reg;
    logic             valid_next;
    cftx_pkg::frame_t frame_reg;
    cftx_pkg::frame_t frame_next;

    // Flush empties, pop shifts toward the head, push fills the first free cell
    always_comb begin
        valid_next = valid_reg;
        frame_next = frame_reg;
        if (ctrl.flush) begin
            valid_next = 1'b0;
        end else if (ctrl.pop) begin
            valid_next = next_valid;
            frame_next = next_frame;
        end else if (ctrl.push && !valid_reg && prev_valid) begin
            valid_next = 1'b1;
            frame_next = new_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold frame data; no reset needed
    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign valid = valid_reg;
    assign frame = frame_reg;

endmodule

`default_nettype wire

[rtl/cftx_chain.sv]
// Row of queue cells with the head at cell 0, plus the fill counter.
// Depends on cftx_pkg and cftx_cell.
`default_nettype none

module cftx_chain #(
    parameter int QUEUE_DEPTH = cftx_pkg::QUEUE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  cftx_pkg::chain_ctrl_t ctrl,
    input  cftx_pkg::frame_t      new_frame,
    output cftx_pkg::chain_stat_t stat,
    output cftx_pkg::frame_t      head_frame,
    output logic [CNT_W-1:0]      count_next
);

    logic [QUEUE_DEPTH-1:0] valid;
    cftx_pkg::frame_t       frames [QUEUE_DEPTH];
    logic [CNT_W-1:0]       count_reg;

    // Instantiate the cell row; the ends see an always-full left and empty right
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic             prev_v;
        logic             next_v;
        cftx_pkg::frame_t next_f;

        if (i == 0) begin : g_first
            assign prev_v = 1'b1;
        end else begin : g_mid_prev
            assign prev_v = valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign next_v = 1'b0;
            assign next_f = '0;
        end else begin : g_mid_next
            assign next_v = valid[i+1];
            assign next_f = frames[i+1];
        end

        cftx_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_frame (next_f),
            .new_frame  (new_frame),
            .valid      (valid[i]),
            .frame      (frames[i])
        );
    end

    // Track the fill level alongside the valid flags
    always_comb begin
        count_next = count_reg;
        if (ctrl.flush) begin
            count_next = '0;
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (ctrl.push) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign stat.head_valid = valid[0];
    assign stat.full       = valid[QUEUE_DEPTH-1];
    assign head_frame      = frames[0];

endmodule

`default_nettype wire

[rtl/can_tx_frame_fifo.sv]
// Top level of the CAN transmit frame queue: command decode, sender state
// machine, overflow counter and result register. Depends on cftx_pkg, cftx_chain.
//
//   channel | ports                     | direction | content
//   --------+---------------------------+-----------+-------------------------
//   input   | s_valid, s_ready, s_data  | in        | push or service tick
//   result  | m_valid, m_ready, m_data  | out       | one status per input
//
// Each accepted transaction is decoded combinationally; its result appears in the result
// register on the next cycle. One transaction per cycle is sustained while
// the result side drains; s_ready drops only while the result register holds
// an untaken result. The queue is a row of cells that shift toward the head
// on each dequeue. Synchronous active-low reset empties the queue at once;
// no clearing pass is needed.
`default_nettype none

module can_tx_frame_fifo #(
    parameter int QUEUE_DEPTH = cftx_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  cftx_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output cftx_pkg::out_item_t m_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cftx_pkg::sender_state_t state_reg;
    cftx_pkg::sender_state_t state_next;
    logic [31:0]             ovf_reg;
    logic [31:0]             ovf_next;
    logic                    m_valid_reg;
    cftx_pkg::out_item_t     m_data_reg;
    cftx_pkg::out_item_t     result;
    cftx_pkg::chain_ctrl_t   ctrl;
    cftx_pkg::chain_stat_t   stat;
    cftx_pkg::frame_t        head_frame;
    cftx_pkg::frame_t        new_frame;
    logic [CNT_W-1:0]        count_next;
    logic                    take;

    // Accept when the result register is free or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    assign new_frame = cftx_pkg::make_frame(s_data);

    cftx_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .new_frame  (new_frame),
        .stat       (stat),
        .head_frame (head_frame),
        .count_next (count_next)
    );

    // Decode the command, run the sender and build the result
    always_comb begin
        state_next = state_reg;
        ovf_next   = ovf_reg;
        ctrl       = '0;
        result     = '0;
        if (take) begin
            unique case (s_data.cmd) inside
                cftx_pkg::CMD_PUSH_STD, cftx_pkg::CMD_PUSH_EXT: begin
                    if (stat.full) begin
                        ctrl.flush = 1'b1;
                        ovf_next   = ovf_reg + 32'd1;
                    end else begin
                        ctrl.push       = 1'b1;
                        result.accepted = 1'b1;
                    end
                end
                cftx_pkg::CMD_TICK: begin
                    unique case (state_reg)
                        cftx_pkg::SND_IDLE: begin
                            if (stat.head_valid) begin
                                ctrl.pop          = 1'b1;
                                state_next        = cftx_pkg::SND_WAIT;
                                result.tx_start   = 1'b1;
                                result.tx_id      = head_frame.id;
                                result.tx_extended = head_frame.ext;
                                result.tx_len     = head_frame.len;
                                result.tx_payload = head_frame.payload;
                            end
                        end
                        cftx_pkg::SND_WAIT: begin
                            if (s_data.tx_done) begin
                                state_next              = cftx_pkg::SND_IDLE;
                                result.clear_tx_request = 1'b1;
                            end
                        end
                        default: begin
                            state_next = cftx_pkg::SND_IDLE;
                        end
                    endcase
                    result.reinit_request = s_data.bus_off;
                end
                default: begin
                end
            endcase
        end
        result.waiting        = (state_next == cftx_pkg::SND_WAIT);
        result.overflow_count = ovf_next;
        result.queued         = cftx_pkg::QUEUED_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cftx_pkg::SND_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the overflow counter and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ovf_reg <= ovf_next;
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result on each accepted transaction
    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/cftx_checker.sv]
// Port-level checker for the CAN transmit frame queue, bound to the top level.
// Depends on cftx_pkg and can_tx_frame_fifo.
`default_nettype none

module cftx_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 m_valid,
    input wire                 m_ready,
    input cftx_pkg::out_item_t m_data
);

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // Issuing a frame leaves the sender waiting
    a_start_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.tx_start |-> m_data.waiting)
        else $error("frame issued but sender not waiting");

    // Completion returns the sender to idle without a new issue
    a_done_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clear_tx_request |-> !m_data.waiting && !m_data.tx_start)
        else $error("completion with sender still busy");

endmodule

bind can_tx_frame_fifo cftx_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for can_tx_frame_fifo: directed and random pushes, ticks and
// unused commands, with a behavioral prediction of the queue checked field by field.
// Depends on cftx_pkg and the can_tx_frame_fifo RTL.
`default_nettype none

module tb;
    import cftx_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 750;
    localparam int IDLE_PCT     = 28;
    localparam int STEADY_LO    = 300;
    localparam int STEADY_HI    = 420;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Predicted queue state
    logic [4:0]  wr_ptr;
    logic [4:0]  rd_ptr;
    logic [31:0] drop_count;
    logic        sender_busy;
    frame_t      held_frames [DEPTH];

    in_item_t  frames_to_send [$];
    out_item_t expected_status [$];
    out_item_t got_status;
    int        total_items;
    int        items_sent   = 0;
    int        results_seen = 0;
    int        hold_left    = 0;
    bit        hold_done    = 1'b0;
    int        idle_cycles  = 0;
    int        n_errors     = 0;

    can_tx_frame_fifo dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance the predicted queue by one transaction and return its status
    function automatic out_item_t step_tx_queue(input in_item_t it);
        out_item_t   res;
        frame_t      fr;
        logic [4:0]  fill;
        logic [3:0]  len;
        res  = '0;
        fill = wr_ptr - rd_ptr;
        if (it.cmd == CMD_PUSH_STD || it.cmd == CMD_PUSH_EXT) begin
            if (fill >= 5'(DEPTH)) begin
                // full: count the drop and flush everything
                drop_count = drop_count + 32'd1;
                rd_ptr     = wr_ptr;
            end else begin
                len    = (it.data_len > 4'd8) ? 4'd8 : it.data_len;
                fr.ext = (it.cmd == CMD_PUSH_EXT);
                fr.id  = fr.ext ? it.frame_id : {18'd0, it.frame_id[10:0]};
                fr.len = len;
                for (int b = 0; b < 8; b++) begin
                    fr.payload[b*8 +: 8] = (4'(b) < len) ? it.payload[b*8 +: 8] : 8'h00;
                end
                held_frames[wr_ptr[3:0]] = fr;
                wr_ptr       = wr_ptr + 5'd1;
                res.accepted = 1'b1;
            end
        end else if (it.cmd == CMD_TICK) begin
            if (!sender_busy) begin
                if (fill != 5'd0) begin
                    fr               = held_frames[rd_ptr[3:0]];
                    res.tx_start     = 1'b1;
                    res.tx_id        = fr.id;
                    res.tx_extended  = fr.ext;
                    res.tx_len       = fr.len;
                    res.tx_payload   = fr.payload;
                    rd_ptr           = rd_ptr + 5'd1;
                    sender_busy      = 1'b1;
                end
            end else if (it.tx_done) begin
                sender_busy          = 1'b0;
                res.clear_tx_request = 1'b1;
            end
            res.reinit_request = it.bus_off;
        end
        res.waiting        = sender_busy;
        res.overflow_count = drop_count;
        res.queued         = wr_ptr - rd_ptr;
        return res;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] cmd, input logic [28:0] id,
                                           input logic [3:0] len, input logic [63:0] pay,
                                           input logic done, input logic boff);
        in_item_t it;
        it.cmd      = cmd;
        it.frame_id = id;
        it.data_len = len;
        it.payload  = pay;
        it.tx_done  = done;
        it.bus_off  = boff;
        return it;
    endfunction

    function automatic in_item_t random_item(input int push_pct);
        logic [1:0] cmd;
        logic [3:0] len;
        int         roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            cmd = CMD_UNUSED;
        else if (roll < 3 + push_pct)
            cmd = $urandom_range(0, 1) ? CMD_PUSH_EXT : CMD_PUSH_STD;
        else
            cmd = CMD_TICK;
        len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
        return make_item(cmd, 29'($urandom), len, {$urandom, $urandom},
                         1'($urandom_range(0, 1)), ($urandom_range(0, 5) == 0));
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            n_errors++;
        end
    endtask

    // Stimulus and end of run
    initial begin
        int burst;
        int mode;
        int push_pct;
        int n_rand;

        // empty idle queue, reinit on tick
        frames_to_send.push_back(make_item(CMD_TICK, '0, '0, '0, 1'b1, 1'b1));
        // id extremes, length extremes, tick inputs on push
        frames_to_send.push_back(make_item(CMD_PUSH_STD, '1, 4'd8, '1, 1'b1, 1'b1));
        frames_to_send.push_back(make_item(CMD_PUSH_EXT, '1, 4'd15, '1, 1'b0, 1'b1));
        frames_to_send.push_back(make_item(CMD_PUSH_STD, '0, 4'd0, '1, 1'b1, 1'b0));
        frames_to_send.push_back(make_item(CMD_PUSH_EXT, '0, 4'd3, {$urandom, $urandom},
                                           1'b0, 1'b0));
        frames_to_send.push_back(make_item(CMD_PUSH_STD, 29'h155, 4'd9, '1, 1'b0, 1'b0));
        frames_to_send.push_back(make_item(CMD_UNUSED, '1, '1, '1, 1'b1, 1'b1));
        // issue, wait, complete with bus-off, issue, complete
        frames_to_send.push_back(make_item(CMD_TICK, '1, '1, '1, 1'b0, 1'b0));
        frames_to_send.push_back(make_item(CMD_TICK, '0, '0, '0, 1'b0, 1'b0));
        frames_to_send.push_back(make_item(CMD_TICK, '0, '0, '0, 1'b1, 1'b1));
        frames_to_send.push_back(make_item(CMD_TICK, '0, '0, '0, 1'b0, 1'b0));
        frames_to_send.push_back(make_item(CMD_TICK, '0, '0, '0, 1'b1, 1'b0));
        // fill the ring, then overflow and flush
        for (int i = 0; i < DEPTH - 2; i++) begin
            frames_to_send.push_back(make_item(CMD_PUSH_EXT, 29'($urandom),
                                               4'($urandom_range(0, 8)),
                                               {$urandom, $urandom}, 1'b0, 1'b0));
        end
        frames_to_send.push_back(make_item(CMD_TICK, '0, '0, '0, 1'b0, 1'b0));

        // random bursts: push-heavy, tick-heavy, mixed and push floods
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            burst = $urandom_range(5, 40);
            mode  = $urandom_range(0, 3);
            case (mode)
                0: push_pct = 80;
                1: push_pct = 20;
                2: push_pct = 48;
                default: push_pct = 97;
            endcase
            for (int i = 0; i < burst; i++) begin
                frames_to_send.push_back(random_item(push_pct));
            end
            n_rand += burst;
        end
        total_items = frames_to_send.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_sent < total_items || expected_status.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0 && expected_status.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Driver: offer pending transactions, predict each one as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            wr_ptr      = '0;
            rd_ptr      = '0;
            drop_count  = '0;
            sender_busy = 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_status.push_back(step_tx_queue(s_data));
                items_sent++;
            end
            if (frames_to_send.size() != 0 &&
                ((items_sent >= STEADY_LO && items_sent < STEADY_HI) ||
                 $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_data  <= frames_to_send.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_status.size() == 0) begin
                    $error("unexpected result transaction: %h", m_data);
                    n_errors++;
                end else begin
                    got_status = expected_status.pop_front();
                    check_field("accepted", 64'(got_status.accepted),
                                64'(m_data.accepted));
                    check_field("tx_start", 64'(got_status.tx_start),
                                64'(m_data.tx_start));
                    check_field("tx_id", 64'(got_status.tx_id), 64'(m_data.tx_id));
                    check_field("tx_extended", 64'(got_status.tx_extended),
                                64'(m_data.tx_extended));
                    check_field("tx_len", 64'(got_status.tx_len), 64'(m_data.tx_len));
                    check_field("tx_payload", got_status.tx_payload, m_data.tx_payload);
                    check_field("clear_tx_request", 64'(got_status.clear_tx_request),
                                64'(m_data.clear_tx_request));
                    check_field("reinit_request", 64'(got_status.reinit_request),
                                64'(m_data.reinit_request));
                    check_field("waiting", 64'(got_status.waiting), 64'(m_data.waiting));
                    check_field("overflow_count", 64'(got_status.overflow_count),
                                64'(m_data.overflow_count));
                    check_field("queued", 64'(got_status.queued), 64'(m_data.queued));
                end
            end
            // hold off once for a long stretch so the input side backs up
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (results_seen >= STEADY_LO && results_seen < STEADY_HI) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

[can_tx_frame_fifo.f]
rtl/cftx_pkg.sv
rtl/cftx_cell.sv
rtl/cftx_chain.sv
rtl/can_tx_frame_fifo.sv
rtl/cftx_checker.sv
tb/tb.sv
